// ----- src/dcl_pkg.sv -----
// ----------------------------------------------------------------------------
// dcl_pkg
// Types and constants that the color labeler modules share.
// ----------------------------------------------------------------------------
package dcl_pkg;

  localparam int unsigned ColorW = 24;
  localparam int unsigned LabelW = 8;
  localparam int unsigned CountW = 9;

  typedef struct packed {
    logic       frame_start;
    logic [7:0] chan_blue;
    logic [7:0] chan_green;
    logic [7:0] chan_red;
  } pixel_t;

  typedef struct packed {
    logic [LabelW-1:0] segment_label;
    logic              is_new_color;
    logic [CountW-1:0] segment_count;
    logic              table_overflow;
  } label_t;

endpackage

// ----- src/distinct_color_labeler.sv -----
// ----------------------------------------------------------------------------
// distinct_color_labeler
// Assigns each pixel color a label in order of first appearance per frame.
// ----------------------------------------------------------------------------
// Input channel: in_valid_i / in_stall_o carry one pixel beat (three color
// bytes and a frame-start flag). A beat with frame_start set empties the
// color table before its own pixel is looked up.
// Output channel: out_valid_o / out_stall_i carry one label beat per pixel:
// label, new-color mark, colors stored so far and a table-full flag.
// The table is scanned one entry per cycle through the single read port
// of the color memory. A color found at table position P is labeled once
// entry P compares equal; a new color or a table-full miss is labeled
// once every stored color has been compared, or at once if none is
// stored. The result then goes on to the output register.
// One pixel is in flight at a time; the next is taken in the cycle after
// the previous result moves into the output register.
// Reset empties the table at once (only the count is cleared); no sweep.
// While the receiver stalls, the output beat holds and the block finishes
// the next pixel, then waits with its result until the output frees up.
// ----------------------------------------------------------------------------
module distinct_color_labeler #(
  parameter int unsigned MAX_LABELS = 256
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  dcl_pkg::pixel_t  in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output dcl_pkg::label_t  out_data_o
);

  localparam int unsigned AddrW = (MAX_LABELS > 1) ? $clog2(MAX_LABELS) : 1;
  localparam int unsigned CntW  = $clog2(MAX_LABELS + 1);

  logic                       pix_ready;
  logic                       res_valid;
  logic                       res_ready;
  dcl_pkg::label_t            res;
  logic                       rd_en;
  logic [AddrW-1:0]           rd_addr;
  logic [dcl_pkg::ColorW-1:0] rd_data;
  logic                       wr_en;
  logic [AddrW-1:0]           wr_addr;
  logic [dcl_pkg::ColorW-1:0] wr_data;

  logic                       out_valid_q;
  dcl_pkg::label_t            out_q;

  dcl_color_mem #(
    .Depth (MAX_LABELS),
    .AddrW (AddrW)
  ) u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  dcl_search #(
    .MaxLabels (MAX_LABELS),
    .AddrW     (AddrW),
    .CntW      (CntW)
  ) u_search (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pix_valid_i (in_valid_i),
    .pix_i       (in_data_i),
    .pix_ready_o (pix_ready),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_ready_i (res_ready),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr),
    .rd_data_i   (rd_data),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .wr_data_o   (wr_data)
  );

  assign in_stall_o = !pix_ready;

  // output register frees when empty or when its beat goes out this cycle
  assign res_ready = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- src/dcl_color_mem.sv -----
// ----------------------------------------------------------------------------
// dcl_color_mem
// Color table: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module dcl_color_mem #(
  parameter int unsigned Depth = 256,
  parameter int unsigned AddrW = 8
) (
  input  logic                      clk_i,
  input  logic                      wr_en_i,
  input  logic [AddrW-1:0]          wr_addr_i,
  input  logic [dcl_pkg::ColorW-1:0] wr_data_i,
  input  logic                      rd_en_i,
  input  logic [AddrW-1:0]          rd_addr_i,
  output logic [dcl_pkg::ColorW-1:0] rd_data_o
);

  logic [dcl_pkg::ColorW-1:0] mem_q [Depth];
  logic [dcl_pkg::ColorW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ----- src/dcl_search.sv -----
// ----------------------------------------------------------------------------
// dcl_search
// Scans the color table one entry per cycle, then labels the pixel and
// appends a new color if there is room. Holds the count of stored colors.
// ----------------------------------------------------------------------------
module dcl_search #(
  parameter int unsigned MaxLabels = 256,
  parameter int unsigned AddrW     = 8,
  parameter int unsigned CntW      = 9
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       pix_valid_i,
  input  dcl_pkg::pixel_t            pix_i,
  output logic                       pix_ready_o,
  output logic                       res_valid_o,
  output dcl_pkg::label_t            res_o,
  input  logic                       res_ready_i,
  output logic                       rd_en_o,
  output logic [AddrW-1:0]           rd_addr_o,
  input  logic [dcl_pkg::ColorW-1:0] rd_data_i,
  output logic                       wr_en_o,
  output logic [AddrW-1:0]           wr_addr_o,
  output logic [dcl_pkg::ColorW-1:0] wr_data_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_RESULT
  } state_e;

  state_e                     state_q;
  logic [CntW-1:0]            used_q;
  logic [CntW-1:0]            idx_q;
  logic                       pend_q;
  logic [CntW-1:0]            pend_addr_q;
  logic [dcl_pkg::ColorW-1:0] color_q;
  dcl_pkg::label_t            res_q;

  logic hit;
  logic miss;
  logic full;

  // compare runs in the cycle after the read issue, on the registered read data
  assign hit  = (state_q == S_SEARCH) && pend_q && (rd_data_i == color_q);
  assign miss = (state_q == S_SEARCH) && !hit &&
                ((pend_q && (pend_addr_q == used_q - CntW'(1))) || (used_q == '0));
  assign full = (used_q == CntW'(MaxLabels));

  assign rd_en_o   = (state_q == S_SEARCH) && (idx_q < used_q) && !hit && !miss;
  assign rd_addr_o = idx_q[AddrW-1:0];

  assign wr_en_o   = miss && !full;
  assign wr_addr_o = used_q[AddrW-1:0];
  assign wr_data_o = color_q;

  assign pix_ready_o = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_RESULT);
  assign res_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      used_q      <= '0;
      idx_q       <= '0;
      pend_q      <= 1'b0;
      pend_addr_q <= '0;
      color_q     <= '0;
      res_q       <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (pix_valid_i) begin
            color_q <= {pix_i.chan_red, pix_i.chan_green, pix_i.chan_blue};
            if (pix_i.frame_start) begin
              used_q <= '0;
            end
            idx_q   <= '0;
            pend_q  <= 1'b0;
            state_q <= S_SEARCH;
          end
        end
        S_SEARCH: begin
          pend_q      <= rd_en_o;
          pend_addr_q <= idx_q;
          if (rd_en_o) begin
            idx_q <= idx_q + CntW'(1);
          end
          priority if (hit) begin
            res_q.segment_label  <= dcl_pkg::LabelW'(pend_addr_q);
            res_q.is_new_color   <= 1'b0;
            res_q.segment_count  <= dcl_pkg::CountW'(used_q);
            res_q.table_overflow <= 1'b0;
            state_q              <= S_RESULT;
          end else if (miss) begin
            if (!full) begin
              res_q.segment_label  <= dcl_pkg::LabelW'(used_q);
              res_q.is_new_color   <= 1'b1;
              res_q.segment_count  <= dcl_pkg::CountW'(used_q + CntW'(1));
              res_q.table_overflow <= 1'b0;
              used_q               <= used_q + CntW'(1);
            end else begin
              res_q.segment_label  <= '0;
              res_q.is_new_color   <= 1'b0;
              res_q.segment_count  <= dcl_pkg::CountW'(used_q);
              res_q.table_overflow <= 1'b1;
            end
            state_q <= S_RESULT;
          end else begin
            state_q <= S_SEARCH;
          end
        end
        S_RESULT: begin
          if (res_ready_i) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- sim/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for distinct_color_labeler.
// Pixel beats go in through a valid/stall driver with random gaps. A local
// color table predicts every label beat, and each output beat is checked
// field by field against the oldest prediction. The runs cover:
//   - extreme colors and frame-start flags
//   - filling the table until it overflows
//   - random frames drawn from small palettes, mixed with noise
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned TableDepth  = 256;
  localparam int unsigned IdlePct     = 34;
  localparam int unsigned StallLimit  = 2000;
  localparam int unsigned DrainCycles = 300;

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             in_valid_i  = 1'b0;
  logic             in_stall_o;
  dcl_pkg::pixel_t  in_data_i   = '0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  dcl_pkg::label_t  out_data_o;

  // local copy of the color table
  logic [dcl_pkg::ColorW-1:0] color_tbl [TableDepth];
  int unsigned                colors_held    = 0;
  dcl_pkg::label_t            label_q [$];
  int unsigned                mismatch_count = 0;
  int unsigned                quiet_cycles   = 0;
  bit                         calm           = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  distinct_color_labeler #(
    .MAX_LABELS(TableDepth)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  function automatic dcl_pkg::label_t label_pixel(input dcl_pkg::pixel_t px);
    logic [dcl_pkg::ColorW-1:0] color;
    dcl_pkg::label_t            res;
    bit                         found;
    int unsigned                pos;
    res   = '0;
    found = 1'b0;
    pos   = 0;
    if (px.frame_start) colors_held = 0;
    color = {px.chan_red, px.chan_green, px.chan_blue};
    for (int unsigned i = 0; i < colors_held; i++) begin
      if (!found && color_tbl[i] == color) begin
        found = 1'b1;
        pos   = i;
      end
    end
    if (!found) begin
      if (colors_held < TableDepth) begin
        color_tbl[colors_held] = color;
        pos = colors_held;
        colors_held++;
        res.is_new_color = 1'b1;
      end else begin
        // table full: label 0, nothing stored
        res.table_overflow = 1'b1;
      end
    end
    res.segment_label = pos[dcl_pkg::LabelW-1:0];
    res.segment_count = colors_held[dcl_pkg::CountW-1:0];
    return res;
  endfunction

  // predict on each input beat, check each output beat
  always @(posedge clk_i) begin
    dcl_pkg::label_t want;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) label_q.push_back(label_pixel(in_data_i));
      if (out_valid_o && !out_stall_i) begin
        if (label_q.size() == 0) begin
          $error("label beat with nothing expected: %h", out_data_o);
          mismatch_count++;
        end else begin
          want = label_q.pop_front();
          if (out_data_o.segment_label !== want.segment_label) begin
            $error("segment_label: expected %0d, got %0d",
                   want.segment_label, out_data_o.segment_label);
            mismatch_count++;
          end
          if (out_data_o.is_new_color !== want.is_new_color) begin
            $error("is_new_color: expected %0d, got %0d",
                   want.is_new_color, out_data_o.is_new_color);
            mismatch_count++;
          end
          if (out_data_o.segment_count !== want.segment_count) begin
            $error("segment_count: expected %0d, got %0d",
                   want.segment_count, out_data_o.segment_count);
            mismatch_count++;
          end
          if (out_data_o.table_overflow !== want.table_overflow) begin
            $error("table_overflow: expected %0d, got %0d",
                   want.table_overflow, out_data_o.table_overflow);
            mismatch_count++;
          end
        end
      end
    end
  end

  // watchdog: cycles with no beat on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == StallLimit) begin
      $display("tb: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  always @(posedge clk_i) begin
    out_stall_i <= !calm && ($urandom_range(99) < IdlePct);
  end

  // color is {red, green, blue}; valid stays up until the beat is taken
  task automatic send_pixel(input bit fs, input logic [dcl_pkg::ColorW-1:0] color);
    dcl_pkg::pixel_t px;
    px.frame_start = fs;
    px.chan_red    = color[23:16];
    px.chan_green  = color[15:8];
    px.chan_blue   = color[7:0];
    while (!calm && $urandom_range(99) < IdlePct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= px;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic test_first_labels();
    // first beat after reset carries no flag: table starts empty
    send_pixel(1'b0, 24'h000000);
    send_pixel(1'b0, 24'hFFFFFF);
    send_pixel(1'b0, 24'h000000);
    send_pixel(1'b0, 24'hFFFFFF);
    send_pixel(1'b0, 24'h0000FF);
    send_pixel(1'b0, 24'h00FF00);
    send_pixel(1'b0, 24'hFF0000);
    send_pixel(1'b0, 24'h000001);
    send_pixel(1'b0, 24'h0000FF);
    // new frame: known colors start over
    send_pixel(1'b1, 24'hFFFFFF);
    send_pixel(1'b0, 24'h000000);
    send_pixel(1'b1, 24'hFFFFFF);
    send_pixel(1'b1, 24'hFFFFFF);
    send_pixel(1'b0, 24'h800000);
    send_pixel(1'b0, 24'h008000);
    send_pixel(1'b0, 24'h000080);
    send_pixel(1'b0, 24'h7F7F7F);
    send_pixel(1'b0, 24'hFFFFFF);
  endtask

  task automatic test_table_full();
    logic [dcl_pkg::ColorW-1:0] fill [TableDepth];
    // blue byte = index keeps all fill colors distinct
    for (int unsigned j = 0; j < TableDepth; j++) begin
      fill[j] = {16'($urandom_range(16'hFFFF)), j[7:0]};
      send_pixel(j == 0, fill[j]);
    end
    for (int unsigned k = 0; k < 24; k++) begin
      if ($urandom_range(1)) send_pixel(1'b0, 24'($urandom_range(24'hFFFFFF)));
      else send_pixel(1'b0, fill[$urandom_range(TableDepth - 1)]);
    end
    send_pixel(1'b0, fill[TableDepth - 1]);
    // flag while full empties the table
    send_pixel(1'b1, 24'($urandom_range(24'hFFFFFF)));
    send_pixel(1'b0, fill[0]);
    send_pixel(1'b0, fill[TableDepth - 1]);
  endtask

  task automatic test_random_frames(input int unsigned item_goal);
    logic [dcl_pkg::ColorW-1:0] palette [32];
    int unsigned                sent;
    int unsigned                kind;
    int unsigned                n;
    int unsigned                psize;
    sent = 0;
    while (sent < item_goal) begin
      calm = (sent >= 200 && sent < 400);
      kind = $urandom_range(99);
      if (kind < 2) begin
        // flood a frame up to or past the table size
        n = TableDepth + $urandom_range(40);
        for (int unsigned j = 0; j < n; j++) begin
          send_pixel(j == 0, {16'($urandom_range(16'hFFFF)), j[7:0]});
        end
      end else if (kind < 18) begin
        n = $urandom_range(1, 8);
        for (int unsigned j = 0; j < n; j++) begin
          send_pixel($urandom_range(9) == 0, 24'($urandom_range(24'hFFFFFF)));
        end
      end else begin
        psize = $urandom_range(1, 24);
        n     = $urandom_range(4, 48);
        for (int unsigned p = 0; p < psize; p++) begin
          palette[p] = 24'($urandom_range(24'hFFFFFF));
        end
        for (int unsigned j = 0; j < n; j++) begin
          // mostly a clean frame start, sometimes a missing or stray flag
          if (j == 0) send_pixel($urandom_range(9) < 8, palette[$urandom_range(psize - 1)]);
          else send_pixel($urandom_range(32) == 0, palette[$urandom_range(psize - 1)]);
        end
      end
      sent += n;
    end
    calm = 1'b0;
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_first_labels();
    test_table_full();
    test_random_frames(1250);
    in_valid_i <= 1'b0;
    while (label_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
